>>> design/command_response_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// command response sequencer assertion macros
// shared assertion wrappers clocked on clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef COMMAND_RESPONSE_SEQUENCER_UNIT_DEFINES_SVH
`define COMMAND_RESPONSE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define CRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// shared types, codes, constants and the reply pattern table
// ----------------------------------------------------------------------------
package crs_pkg;

  // default sizing
  localparam int BUFFER_BYTES_DEF  = 256;
  localparam int STEPS_DEF         = 6;
  localparam int PATTERN_BYTES_DEF = 4;

  // configuration register indexes
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RETRIES = 2'd1;
  localparam logic [1:0] CFG_STEPS   = 2'd2;

  // configuration reset values
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;
  localparam logic [3:0]  RETRIES_RST = 4'd3;
  localparam logic [3:0]  STEPS_RST   = 4'd6;

  // input word kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_POLL = 2'd2;

  // actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_SEND   = 2'd1;
  localparam logic [1:0] ACT_RESEND = 2'd2;
  localparam logic [1:0] ACT_RESET  = 2'd3;

  // lamp colours
  localparam logic [1:0] LAMP_KEEP  = 2'd0;
  localparam logic [1:0] LAMP_BLUE  = 2'd1;
  localparam logic [1:0] LAMP_GREEN = 2'd2;
  localparam logic [1:0] LAMP_RED   = 2'd3;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  // receive buffer control from the step logic
  typedef struct packed {
    logic take;
    logic clear;
  } buf_ctl_t;

  // one result word
  typedef struct packed {
    logic [1:0] action;
    logic [2:0] command_index;
    logic [1:0] lamp;
    logic       all_done;
  } result_t;

  // expected reply, packed first character most significant
  function automatic logic [31:0] pat_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd1:    w = 32'h2B44_4549;  // +DEI
      3'd2:    w = 32'h2B41_4549;  // +AEI
      3'd3:    w = 32'h2B41_4B59;  // +AKY
      default: w = 32'h0000_4F4B;  // OK
    endcase
    return w;
  endfunction

  function automatic logic [3:0] pat_len(input logic [2:0] idx);
    logic [3:0] n;
    case (idx)
      3'd1, 3'd2, 3'd3: n = 4'd4;
      default:          n = 4'd2;
    endcase
    return n;
  endfunction

endpackage

>>> design/crs_in_reg.sv
// ----------------------------------------------------------------------------
// crs_in_reg
// input register holding one word until the step logic takes it
// ----------------------------------------------------------------------------
module crs_in_reg import crs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_rx_byte,
  input  logic       adv,
  output logic       vld,
  output logic [1:0] kind,
  output logic [7:0] rx_byte
);

  logic       vld_r, vld_nxt;
  logic [1:0] kind_r;
  logic [7:0] byte_r;
  logic       load;

  // hold while the current word cannot move on
  assign in_stall = vld_r && !adv;
  assign load     = in_valid && !in_stall;
  assign vld_nxt  = load || (vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= in_kind;
      byte_r <= in_rx_byte;
    end
  end

  assign vld     = vld_r;
  assign kind    = kind_r;
  assign rx_byte = byte_r;

endmodule

>>> design/crs_matcher.sv
// ----------------------------------------------------------------------------
// crs_matcher
// receive buffer fill count and shift-register reply matcher
// ----------------------------------------------------------------------------
module crs_matcher import crs_pkg::*; #(
  parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  buf_ctl_t   ctl,
  input  logic [7:0] rx_byte,
  input  logic [2:0] pat_idx,
  output logic       reply_seen
);

  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
  localparam int WIN_W = 8 * PATTERN_BYTES;
  localparam int REC_W = 8 * (PATTERN_BYTES - 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [REC_W-1:0] recent_r, recent_nxt;
  logic             seen_r, seen_nxt;
  logic [WIN_W-1:0] win;
  logic [63:0]      word64;
  logic [3:0]       plen;
  logic             hit;
  logic             room;

  assign room   = count_r < CNT_W'(BUFFER_BYTES);
  assign win    = {recent_r, rx_byte};
  assign word64 = {32'b0, pat_word(pat_idx)};

  // a reply longer than the window is compared on its tail
  always_comb begin
    plen = pat_len(pat_idx);
    if (int'(plen) > PATTERN_BYTES) plen = 4'(PATTERN_BYTES);
  end

  // byte-wise compare over the window
  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      if (i < int'(plen) && win[8*i +: 8] != word64[8*i +: 8]) hit = 1'b0;
    end
  end

  // buffer update
  always_comb begin
    count_nxt  = count_r;
    recent_nxt = recent_r;
    seen_nxt   = seen_r;
    if (ctl.clear) begin
      count_nxt  = '0;
      recent_nxt = '0;
      seen_nxt   = 1'b0;
    end else if (ctl.take && room) begin
      count_nxt  = count_r + CNT_W'(1);
      recent_nxt = win[REC_W-1:0];
      if (hit && int'(count_nxt) >= int'(plen)) seen_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      recent_r <= '0;
      seen_r   <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      recent_r <= recent_nxt;
      seen_r   <= seen_nxt;
    end
  end

  assign reply_seen = seen_r;

endmodule

>>> design/crs_ctrl.sv
// ----------------------------------------------------------------------------
// crs_ctrl
// step sequencing, reply timer and retry count for one word per cycle while adv is high
// ----------------------------------------------------------------------------
module crs_ctrl import crs_pkg::*; #(
  parameter int STEPS = STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  logic [1:0]  kind,
  input  logic [15:0] timeout_ticks,
  input  logic [3:0]  max_retries,
  input  logic [3:0]  step_count,
  input  logic        reply_seen,
  output buf_ctl_t    buf_ctl,
  output logic [2:0]  pat_idx,
  output result_t     res
);

  logic [3:0]  step_r, step_nxt;
  logic        sent_r, sent_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [3:0]  retries_r, retries_nxt;
  logic [3:0]  in_use;

  // steps in use is the smaller of the register and the build size
  assign in_use  = (step_count > 4'(STEPS)) ? 4'(STEPS) : step_count;
  assign pat_idx = step_r[2:0];

  always_comb begin
    step_nxt    = step_r;
    sent_nxt    = sent_r;
    elapsed_nxt = elapsed_r;
    retries_nxt = retries_r;
    buf_ctl     = '0;
    res         = '0;
    if (adv) begin
      case (kind)
        KIND_BYTE: begin
          buf_ctl.take = 1'b1;
        end
        KIND_TICK: begin
          if (elapsed_r != TICKS_MAX) elapsed_nxt = elapsed_r + 16'd1;
        end
        KIND_POLL: begin
          if (step_r < in_use) begin
            if (!sent_r) begin
              // first send of this step
              res.action        = ACT_SEND;
              res.command_index = step_r[2:0];
              res.lamp          = LAMP_BLUE;
              elapsed_nxt       = '0;
              sent_nxt          = 1'b1;
            end else if (reply_seen) begin
              // reply matched, move on
              res.lamp      = LAMP_GREEN;
              step_nxt      = step_r + 4'd1;
              sent_nxt      = 1'b0;
              retries_nxt   = max_retries;
              buf_ctl.clear = 1'b1;
            end else if (elapsed_r >= timeout_ticks) begin
              res.lamp          = LAMP_RED;
              res.command_index = step_r[2:0];
              if (retries_r != 4'd0) begin
                res.action  = ACT_RESEND;
                elapsed_nxt = '0;
                retries_nxt = retries_r - 4'd1;
              end else begin
                // out of retries: reset the modem and start over
                res.action    = ACT_RESET;
                buf_ctl.clear = 1'b1;
                sent_nxt      = 1'b0;
                step_nxt      = '0;
                retries_nxt   = max_retries;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.all_done = step_nxt >= in_use;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      sent_r    <= 1'b0;
      elapsed_r <= '0;
      retries_r <= RETRIES_RST;
    end else begin
      step_r    <= step_nxt;
      sent_r    <= sent_nxt;
      elapsed_r <= elapsed_nxt;
      retries_r <= retries_nxt;
    end
  end

endmodule

>>> design/command_response_sequencer_unit.sv
// ----------------------------------------------------------------------------
// command_response_sequencer_unit
// steps a modem through a fixed command list driven by bytes, ticks and polls
// ----------------------------------------------------------------------------
// Takes one word per clock unless stalled and returns exactly one result word for
// each, via the input register, then the result register. The step logic and the
// reply matcher handle each word in the input register, so a word can follow in
// the very next cycle; the input side stalls only while the result register is
// full and stalled itself. Configuration is written through cfg_we/cfg_index/
// cfg_wdata, by the user only while no word is in flight; the block does not check.
module command_response_sequencer_unit import crs_pkg::*; #(
  parameter int BUFFER_BYTES  = BUFFER_BYTES_DEF,
  parameter int STEPS         = STEPS_DEF,
  parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [2:0]  out_command_index,
  output logic [1:0]  out_lamp,
  output logic        out_all_done
);

`include "command_response_sequencer_unit_defines.svh"

  logic [15:0] timeout_r;
  logic [3:0]  retries_r;
  logic [3:0]  steps_r;
  logic        vld;
  logic [1:0]  kind;
  logic [7:0]  rx_byte;
  logic        adv;
  logic        reply_seen;
  logic [2:0]  pat_idx;
  buf_ctl_t    buf_ctl;
  result_t     res;
  logic        out_vld_r, out_vld_nxt;
  result_t     res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      retries_r <= RETRIES_RST;
      steps_r   <= STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_RETRIES: retries_r <= cfg_wdata[3:0];
        CFG_STEPS:   steps_r   <= cfg_wdata[3:0];
        default: begin
        end
      endcase
    end
  end

  // a word moves on when the result register is free or draining
  assign adv = vld && (!out_vld_r || !out_stall);

  crs_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_rx_byte (in_rx_byte),
    .adv        (adv),
    .vld        (vld),
    .kind       (kind),
    .rx_byte    (rx_byte)
  );

  crs_ctrl #(
    .STEPS (STEPS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .kind          (kind),
    .timeout_ticks (timeout_r),
    .max_retries   (retries_r),
    .step_count    (steps_r),
    .reply_seen    (reply_seen),
    .buf_ctl       (buf_ctl),
    .pat_idx       (pat_idx),
    .res           (res)
  );

  crs_matcher #(
    .BUFFER_BYTES  (BUFFER_BYTES),
    .PATTERN_BYTES (PATTERN_BYTES)
  ) u_match (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (buf_ctl),
    .rx_byte    (rx_byte),
    .pat_idx    (pat_idx),
    .reply_seen (reply_seen)
  );

  // result register
  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_action        = res_r.action;
  assign out_command_index = res_r.command_index;
  assign out_lamp          = res_r.lamp;
  assign out_all_done      = res_r.all_done;

  // checks
  `CRS_ASSERT_NEXT(a_adv_gives_result, adv, out_vld_r, "word advanced without a result")
  `CRS_ASSERT_NEXT(a_held_word_kept, vld && !adv, vld, "held input word lost")
  `CRS_ASSERT_NOW(a_action_has_lamp, out_vld_r && out_action != ACT_NONE,
                  out_lamp == LAMP_BLUE || out_lamp == LAMP_RED, "action without lamp")

endmodule
